[hdl/tsse_pkg.sv]
// Shared types and constants of the tile store scan engine.
`timescale 1ns / 1ps

package tsse_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_XOR   = 2'd1,
      OP_SCAN  = 2'd2,
      OP_RUNS  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_XOR,
      ST_WALK,
      ST_FINISH
   } state_type;

   localparam int unsigned MIN_RUN = 4;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   // prime^4: one 32-bit tile is four zero bytes
   localparam logic [31:0] FNV_P2 = 32'(64'(FNV_PRIME) * 64'(FNV_PRIME));
   localparam logic [31:0] FNV_P4 = 32'(64'(FNV_P2) * 64'(FNV_P2));
   // hash of a run of one zero tile
   localparam logic [31:0] FNV_RUN1 = 32'(64'(FNV_BASIS) * 64'(FNV_P4));

   typedef struct packed {
      logic        status;
      logic [11:0] position;
      logic [12:0] run_length;
      logic [31:0] run_hash;
      logic [6:0]  found_count;
   } result_type;

endpackage

[hdl/tile_store_scan_engine_top.sv]
// Tile store with write, xor, nonzero scan and idle run summary.
// Write stores its tile on acceptance; xor reads the tile and writes it back from
// ST_XOR; both report in ST_FINISH. Scan and summary walk up to n tiles, one tile
// per cycle unless results stall, via the single-port memory. One item at a time.
// Reset clears control state and tile_count; tile memory is not cleared.
`timescale 1ns / 1ps

module tile_store_scan_engine_top #(
   parameter int TILE_DEPTH  = 4096,
   parameter int MAX_RESULTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // tdata: tile_index[11:0], tile_value[43:12], result_cap[50:44], zero fill
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   // tuser: opcode[1:0]
   input  logic [1:0]  req_tuser,
   // tdata: position[11:0], run_length[24:12], run_hash[56:25], found_count[63:57]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // tuser: status[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [12:0] csr_wdata
);

   localparam int AW = $clog2(TILE_DEPTH);
   localparam int CW = $clog2(TILE_DEPTH + 1);

   logic [31:0] tile_mem [TILE_DEPTH];

   tsse_pkg::state_type state_ff, state_in;

   logic [12:0]   tile_count_ff;
   logic [CW-1:0] n_tiles;

   logic          runs_mode_ff;
   logic [AW-1:0] idx_ff;
   logic [31:0]   val_ff;
   logic [6:0]    cap_ff;

   logic [CW-1:0] scan_addr_ff;
   logic          rd_valid_ff;
   logic          rd_last_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [31:0]   rd_data_ff;

   logic [6:0]    found_ff;
   logic          in_run_ff;
   logic [AW-1:0] run_start_ff;
   logic [CW-1:0] run_len_ff;
   logic [31:0]   run_hash_ff;

   logic                 pend_valid_ff;
   tsse_pkg::result_type pend_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_last_ff;
   tsse_pkg::result_type rsp_ff;

   // request fields
   logic [11:0] req_idx;
   logic [31:0] req_val;
   logic [6:0]  req_cap;
   logic [6:0]  cap_clamped;
   logic        req_accept;
   logic        idx_in_range;
   tsse_pkg::result_type op_res;

   // walk datapath
   logic          is_zero;
   logic [31:0]   mul_out;
   logic [CW-1:0] ext_len;
   logic [31:0]   ext_hash;
   logic [AW-1:0] ext_start;
   logic          ended;
   logic [CW-1:0] end_len;
   logic [31:0]   end_hash;
   logic [AW-1:0] end_start;
   logic          emit;
   tsse_pkg::result_type hit;
   logic [6:0]    hit_cnt;
   logic          out_free;
   logic          proceed;
   logic          stop;
   logic          issue;

   // memory and result controls
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic          push_en;
   logic          push_last;
   tsse_pkg::result_type push_res;

   assign req_idx = req_tdata[11:0];
   assign req_val = req_tdata[43:12];
   assign req_cap = req_tdata[50:44];

   assign cap_clamped = (req_cap == 7'd0) ? 7'd1 :
                        (req_cap > 7'(MAX_RESULTS)) ? 7'(MAX_RESULTS) : req_cap;

   assign n_tiles = (32'(tile_count_ff) > TILE_DEPTH) ? CW'(TILE_DEPTH)
                                                     : CW'(tile_count_ff);

   assign req_tready   = (state_ff == tsse_pkg::ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign idx_in_range = 32'(req_idx) < 32'(n_tiles);
   assign out_free     = !rsp_valid_ff || rsp_tready;

   // result of a write or xor
   always_comb begin
      op_res          = '0;
      op_res.status   = !idx_in_range;
      op_res.position = req_idx;
   end

   // walk datapath
   assign is_zero   = (rd_data_ff == 32'd0);
   assign mul_out   = run_hash_ff * tsse_pkg::FNV_P4;
   assign ext_len   = in_run_ff ? run_len_ff + CW'(1) : CW'(1);
   assign ext_hash  = in_run_ff ? mul_out : tsse_pkg::FNV_RUN1;
   assign ext_start = in_run_ff ? run_start_ff : rd_idx_ff;
   assign hit_cnt   = found_ff + 7'd1;

   always_comb begin
      ended     = 1'b0;
      end_len   = run_len_ff;
      end_hash  = run_hash_ff;
      end_start = run_start_ff;
      if (!is_zero) begin
         ended = in_run_ff;
      end else if (rd_last_ff) begin
         ended     = 1'b1;
         end_len   = ext_len;
         end_hash  = ext_hash;
         end_start = ext_start;
      end
   end

   always_comb begin
      hit.status      = 1'b0;
      hit.found_count = hit_cnt;
      if (runs_mode_ff) begin
         emit           = ended && (end_len >= CW'(tsse_pkg::MIN_RUN));
         hit.position   = 12'(end_start);
         hit.run_length = 13'(end_len);
         hit.run_hash   = end_hash;
      end else begin
         emit           = !is_zero;
         hit.position   = 12'(rd_idx_ff);
         hit.run_length = 13'd0;
         hit.run_hash   = 32'd0;
      end
   end

   assign proceed = (state_ff == tsse_pkg::ST_WALK) && rd_valid_ff &&
                    (!(emit && pend_valid_ff) || out_free);
   assign stop    = proceed && (rd_last_ff || (emit && hit_cnt == cap_ff));
   assign issue   = (state_ff == tsse_pkg::ST_WALK) && (scan_addr_ff < n_tiles) &&
                    (!rd_valid_ff || proceed) && !stop;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tsse_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_tuser)
                  tsse_pkg::OP_WRITE: state_in = tsse_pkg::ST_FINISH;
                  tsse_pkg::OP_XOR:
                     state_in = idx_in_range ? tsse_pkg::ST_XOR : tsse_pkg::ST_FINISH;
                  default:
                     state_in = (n_tiles == CW'(0)) ? tsse_pkg::ST_FINISH
                                                    : tsse_pkg::ST_WALK;
               endcase
            end
         end
         tsse_pkg::ST_XOR:  state_in = tsse_pkg::ST_FINISH;
         tsse_pkg::ST_WALK: begin
            if (stop) state_in = tsse_pkg::ST_FINISH;
         end
         tsse_pkg::ST_FINISH: begin
            if (out_free) state_in = tsse_pkg::ST_IDLE;
         end
         default: state_in = tsse_pkg::ST_IDLE;
      endcase
   end

   // memory controls and result push
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = rd_data_ff ^ val_ff;
      mem_re    = 1'b0;
      mem_raddr = scan_addr_ff[AW-1:0];
      push_en   = 1'b0;
      push_last = 1'b0;
      push_res  = pend_ff;
      case (state_ff)
         tsse_pkg::ST_IDLE: begin
            mem_raddr = AW'(req_idx);
            mem_waddr = AW'(req_idx);
            mem_wdata = req_val;
            if (req_accept && idx_in_range) begin
               mem_we = (req_tuser == tsse_pkg::OP_WRITE);
               mem_re = (req_tuser == tsse_pkg::OP_XOR);
            end
         end
         tsse_pkg::ST_XOR: mem_we = 1'b1;
         tsse_pkg::ST_WALK: begin
            mem_re  = issue;
            push_en = proceed && emit && pend_valid_ff;
         end
         tsse_pkg::ST_FINISH: begin
            push_en   = out_free;
            push_last = 1'b1;
            if (!pend_valid_ff) begin
               push_res        = '0;
               push_res.status = (n_tiles == CW'(0));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) tile_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= tile_mem[mem_raddr];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tsse_pkg::ST_IDLE;
         tile_count_ff <= 13'd0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         in_run_ff     <= 1'b0;
         found_ff      <= 7'd0;
         scan_addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) tile_count_ff <= csr_wdata;

         if (push_en) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;

         if (req_accept) begin
            scan_addr_ff  <= '0;
            rd_valid_ff   <= 1'b0;
            found_ff      <= 7'd0;
            in_run_ff     <= 1'b0;
            pend_valid_ff <= (req_tuser == tsse_pkg::OP_WRITE) ||
                             (req_tuser == tsse_pkg::OP_XOR);
         end else if (state_ff == tsse_pkg::ST_WALK) begin
            if (stop) rd_valid_ff <= 1'b0;
            else if (issue) rd_valid_ff <= 1'b1;
            else if (proceed) rd_valid_ff <= 1'b0;
            if (issue) scan_addr_ff <= scan_addr_ff + CW'(1);
            if (proceed) begin
               in_run_ff <= is_zero;
               if (emit) begin
                  found_ff      <= hit_cnt;
                  pend_valid_ff <= 1'b1;
               end
            end
         end else if (state_ff == tsse_pkg::ST_FINISH && out_free) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         runs_mode_ff <= (req_tuser == tsse_pkg::OP_RUNS);
         idx_ff       <= AW'(req_idx);
         val_ff       <= req_val;
         cap_ff       <= cap_clamped;
         pend_ff      <= op_res;
      end else if (proceed && emit) begin
         pend_ff <= hit;
      end
      if (issue) begin
         rd_idx_ff  <= scan_addr_ff[AW-1:0];
         rd_last_ff <= (scan_addr_ff + CW'(1)) == n_tiles;
      end
      if (proceed && is_zero) begin
         run_len_ff   <= ext_len;
         run_hash_ff  <= ext_hash;
         run_start_ff <= ext_start;
      end
      if (push_en) begin
         rsp_ff      <= push_res;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.found_count, rsp_ff.run_hash, rsp_ff.run_length,
                        rsp_ff.position};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hdl/tsse_checker.sv]
// Port-level checker of the tile store scan engine and its bind.
`timescale 1ns / 1ps

module tsse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_mid_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[63:57] != 7'd0)
      else $error("non-final item without found count");

   a_error_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("error status on non-final item");

endmodule

bind tile_store_scan_engine_top tsse_checker u_tsse_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
